// ----- design/ray_sphere_nearest_pick_macros.svh -----
// assertion macros for the ray sphere nearest pick block
// used by the top level only; the macros expand to nothing in synthesis
`ifndef RAY_SPHERE_NEAREST_PICK_MACROS_SVH
`define RAY_SPHERE_NEAREST_PICK_MACROS_SVH
`ifndef SYNTHESIS
`define RSNP_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rsnp: same-cycle check failed");
`define RSNP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rsnp: next-cycle check failed");
`else
`define RSNP_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define RSNP_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ----- design/rsnp_pkg.sv -----
// shared widths, register indexes and accumulate codes of the ray sphere pick
// no dependencies
`default_nettype none

package rsnp_pkg;

   localparam int unsigned CoordW   = 32;
   localparam int unsigned DirW     = 16;
   localparam int unsigned RadiusW  = 31;
   localparam int unsigned IdW      = 32;
   localparam int unsigned CsrDataW = 32;
   localparam int unsigned CsrIdxW  = 3;
   localparam int unsigned ReqDataW = 160;

   // origin minus centre
   localparam int unsigned OffW  = CoordW + 1;
   // shared signed multiplier
   localparam int unsigned MulW  = OffW + 1;
   localparam int unsigned ProdW = 2 * MulW;
   // b = offset . dir, Q.30, magnitude below 2^49
   localparam int unsigned BW    = 51;
   localparam int unsigned BMagW = 49;
   localparam int unsigned BLoW  = 25;
   localparam int unsigned BHiW  = BMagW - BLoW;
   // discriminant Q.60 and its floor root Q.30
   localparam int unsigned RootW = 51;
   localparam int unsigned DiscW = 2 * RootW;
   localparam int unsigned RemW  = RootW + 2;
   localparam int unsigned DistW = RootW + 2;
   localparam int unsigned BestW = RootW + 1;
   localparam int unsigned CntW  = 6;

   // Q16.16 squared to Q.60
   localparam int unsigned ScaleSh = 28;
   localparam int unsigned HiSh    = 2 * BLoW;
   localparam int unsigned MidSh   = BLoW + 1;

   localparam logic [CsrIdxW-1:0] CSR_ORIGIN_X = 3'd0;
   localparam logic [CsrIdxW-1:0] CSR_ORIGIN_Y = 3'd1;
   localparam logic [CsrIdxW-1:0] CSR_ORIGIN_Z = 3'd2;
   localparam logic [CsrIdxW-1:0] CSR_DIR_X    = 3'd3;
   localparam logic [CsrIdxW-1:0] CSR_DIR_Y    = 3'd4;
   localparam logic [CsrIdxW-1:0] CSR_DIR_Z    = 3'd5;

   localparam logic signed [DirW-1:0] DirZReset = 16'sd16384;

   typedef enum logic [2:0] {
      ACC_B,
      ACC_SUB_SCALED,
      ACC_ADD_SCALED,
      ACC_ADD_HI,
      ACC_ADD_MID,
      ACC_ADD_LO
   } acc_op_type;

endpackage

`default_nettype wire

// ----- design/ray_sphere_nearest_pick.sv -----
// ray sphere nearest pick
//
// the ray is set through the csr write port (always ready): index 0..2 are
// origin x/y/z in signed Q16.16, index 3..5 direction x/y/z in signed Q2.14
// in the low bits of csr_data; other indexes are dropped. write only while
// the block is idle. after reset the ray is origin zero, direction +z.
// spheres arrive on req_: one per item, tuser low marks an item with no sphere.
// each sphere runs through one shared 34x34 multiplier for ten products
// (three for b, three for |offset|^2, r^2, three for b^2), then a one bit
// per cycle restoring square root of the 102-bit discriminant.
// req_tready is high only while idle, so a new item is taken only once the
// last one is done: a sphere runs the ten multiplier passes and, unless its
// discriminant is negative, the 51 root iterations; an end-only item neither.
// on an item with tlast the nearest id (0 when nothing hit) is loaded into
// the rsp_ register in the finish state after the sphere is done and the
// tracking is cleared; the block waits for a previous result not yet taken.
// reset clears the tracking and any pending result and sets the ray as above.
// depends on rsnp_pkg and ray_sphere_nearest_pick_macros.svh
`default_nettype none
`include "ray_sphere_nearest_pick_macros.svh"

module ray_sphere_nearest_pick (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [rsnp_pkg::CsrIdxW-1:0]   csr_index,
   input  wire logic [rsnp_pkg::CsrDataW-1:0]  csr_data,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   // center_x, center_y, center_z, sphere_radius, sphere_id, one zero pad bit
   input  wire logic [rsnp_pkg::ReqDataW-1:0]  req_tdata,
   // sphere_valid
   input  wire logic                           req_tuser,
   // last_sphere
   input  wire logic                           req_tlast,
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   // picked_id
   output logic [rsnp_pkg::IdW-1:0]            rsp_tdata
);
   import rsnp_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MUL,
      S_CHECK,
      S_ROOT,
      S_EVAL,
      S_PICK,
      S_FINISH
   } state_type;

   localparam logic [CntW-1:0] STEP_BX     = 6'd0;
   localparam logic [CntW-1:0] STEP_BY     = 6'd1;
   localparam logic [CntW-1:0] STEP_BZ     = 6'd2;
   localparam logic [CntW-1:0] STEP_SQX    = 6'd3;
   localparam logic [CntW-1:0] STEP_SQY    = 6'd4;
   localparam logic [CntW-1:0] STEP_SQZ    = 6'd5;
   localparam logic [CntW-1:0] STEP_RR     = 6'd6;
   localparam logic [CntW-1:0] STEP_BHH    = 6'd7;
   localparam logic [CntW-1:0] STEP_BHL    = 6'd8;
   localparam logic [CntW-1:0] STEP_BLL    = 6'd9;
   localparam logic [CntW-1:0] STEP_DRAIN  = 6'd10;
   localparam logic [CntW-1:0] ROOT_LAST   = CntW'(RootW - 1);

   // control state
   state_type                 state_ff, state_in;
   logic [CntW-1:0]           cnt_ff, cnt_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [IdW-1:0]            rsp_data_ff, rsp_data_in;
   logic [IdW-1:0]            best_id_ff, best_id_in;
   logic [BestW-1:0]          best_dist_ff, best_dist_in;
   logic                      prod_vld_ff, prod_vld_in;
   logic signed [CoordW-1:0]  origin_ff [3];
   logic signed [DirW-1:0]    dir_ff [3];

   // payload
   logic signed [OffW-1:0]    off_ff [3];
   logic signed [OffW-1:0]    off_in [3];
   logic [RadiusW-1:0]        radius_ff, radius_in;
   logic [IdW-1:0]            id_ff, id_in;
   logic                      last_ff, last_in;
   logic signed [ProdW-1:0]   prod_ff, prod_in;
   acc_op_type                prod_op_ff, prod_op_in;
   logic signed [BW-1:0]      b_ff, b_in;
   logic signed [DiscW-1:0]   acc_ff, acc_in;
   logic [RemW-1:0]           rem_ff, rem_in;
   logic [RootW-1:0]          root_ff, root_in;
   logic [BestW-1:0]          dist_ff, dist_in;
   logic                      hit_ff, hit_in;

   logic                      accept;
   logic                      rsp_load;
   logic signed [MulW-1:0]    mul_a;
   logic signed [MulW-1:0]    mul_b;
   logic signed [BW-1:0]      b_abs;
   logic [BHiW-1:0]           b_hi;
   logic [BLoW-1:0]           b_lo;
   logic signed [DiscW-1:0]   prod_ext;
   logic [RemW-1:0]           rem_sh;
   logic [RemW-1:0]           trial;
   logic signed [DistW-1:0]   neg_b;
   logic signed [DistW-1:0]   root_ext;
   logic signed [DistW-1:0]   d_near;
   logic signed [DistW-1:0]   d_far;
   logic signed [DistW-1:0]   d_pick;

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // operand select for the shared multiplier
   always_comb begin
      b_abs = b_ff[BW-1] ? -b_ff : b_ff;
      b_hi  = b_abs[BMagW-1:BLoW];
      b_lo  = b_abs[BLoW-1:0];
      mul_a = '0;
      mul_b = '0;
      prod_op_in  = ACC_B;
      prod_vld_in = 1'b0;
      if (state_ff == S_MUL) begin
         prod_vld_in = 1'b1;
         unique case (cnt_ff)
            STEP_BX: begin
               mul_a = MulW'(off_ff[0]);
               mul_b = MulW'(dir_ff[0]);
            end
            STEP_BY: begin
               mul_a = MulW'(off_ff[1]);
               mul_b = MulW'(dir_ff[1]);
            end
            STEP_BZ: begin
               mul_a = MulW'(off_ff[2]);
               mul_b = MulW'(dir_ff[2]);
            end
            STEP_SQX: begin
               mul_a = MulW'(off_ff[0]);
               mul_b = MulW'(off_ff[0]);
               prod_op_in = ACC_SUB_SCALED;
            end
            STEP_SQY: begin
               mul_a = MulW'(off_ff[1]);
               mul_b = MulW'(off_ff[1]);
               prod_op_in = ACC_SUB_SCALED;
            end
            STEP_SQZ: begin
               mul_a = MulW'(off_ff[2]);
               mul_b = MulW'(off_ff[2]);
               prod_op_in = ACC_SUB_SCALED;
            end
            STEP_RR: begin
               mul_a = MulW'(radius_ff);
               mul_b = MulW'(radius_ff);
               prod_op_in = ACC_ADD_SCALED;
            end
            STEP_BHH: begin
               mul_a = MulW'(b_hi);
               mul_b = MulW'(b_hi);
               prod_op_in = ACC_ADD_HI;
            end
            STEP_BHL: begin
               mul_a = MulW'(b_hi);
               mul_b = MulW'(b_lo);
               prod_op_in = ACC_ADD_MID;
            end
            STEP_BLL: begin
               mul_a = MulW'(b_lo);
               mul_b = MulW'(b_lo);
               prod_op_in = ACC_ADD_LO;
            end
            default: begin
               prod_vld_in = 1'b0;
            end
         endcase
      end
      prod_in = mul_a * mul_b;
   end

   // datapath next values
   always_comb begin
      prod_ext = {{(DiscW - ProdW){prod_ff[ProdW-1]}}, prod_ff};
      rem_sh   = {rem_ff[RootW-1:0], acc_ff[DiscW-1 -: 2]};
      trial    = {root_ff, 2'b01};
      neg_b    = -DistW'(b_ff);
      root_ext = DistW'(root_ff);
      d_near   = neg_b - root_ext;
      d_far    = neg_b + root_ext;
      d_pick   = d_near[DistW-1] ? d_far : d_near;

      off_in    = off_ff;
      radius_in = radius_ff;
      id_in     = id_ff;
      last_in   = last_ff;
      b_in      = b_ff;
      acc_in    = acc_ff;
      rem_in    = rem_ff;
      root_in   = root_ff;
      dist_in   = dist_ff;
      hit_in    = hit_ff;

      if (accept) begin
         off_in[0] = OffW'(origin_ff[0]) - OffW'(signed'(req_tdata[31:0]));
         off_in[1] = OffW'(origin_ff[1]) - OffW'(signed'(req_tdata[63:32]));
         off_in[2] = OffW'(origin_ff[2]) - OffW'(signed'(req_tdata[95:64]));
         radius_in = req_tdata[126:96];
         id_in     = req_tdata[158:127];
         last_in   = req_tlast;
         b_in      = '0;
         acc_in    = '0;
      end else if (state_ff == S_ROOT) begin
         // one root bit per cycle, discriminant shifts out two bits at a time
         acc_in = acc_ff <<< 2;
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_ff[RootW-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_ff[RootW-2:0], 1'b0};
         end
      end else if (prod_vld_ff) begin
         unique case (prod_op_ff)
            ACC_B:          b_in   = b_ff + signed'(prod_ff[BW-1:0]);
            ACC_SUB_SCALED: acc_in = acc_ff - (prod_ext <<< ScaleSh);
            ACC_ADD_SCALED: acc_in = acc_ff + (prod_ext <<< ScaleSh);
            ACC_ADD_HI:     acc_in = acc_ff + (prod_ext <<< HiSh);
            ACC_ADD_MID:    acc_in = acc_ff + (prod_ext <<< MidSh);
            ACC_ADD_LO:     acc_in = acc_ff + prod_ext;
            default:        acc_in = acc_ff;
         endcase
      end

      if (state_ff == S_CHECK) begin
         rem_in  = '0;
         root_in = '0;
      end
      if (state_ff == S_EVAL) begin
         hit_in  = !d_pick[DistW-1];
         dist_in = d_pick[BestW-1:0];
      end
   end

   // sequencer next values
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      best_id_in   = best_id_ff;
      best_dist_in = best_dist_ff;
      rsp_load     = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cnt_in   = '0;
               state_in = req_tuser ? S_MUL : S_FINISH;
            end
         end
         S_MUL: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == STEP_DRAIN) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            cnt_in = '0;
            // negative discriminant is a miss
            state_in = acc_ff[DiscW-1] ? S_FINISH : S_ROOT;
         end
         S_ROOT: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == ROOT_LAST) begin
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            state_in = S_PICK;
         end
         S_PICK: begin
            // a stored id of zero counts as nothing found yet
            if (hit_ff && (best_id_ff == '0 || dist_ff < best_dist_ff)) begin
               best_id_in   = id_ff;
               best_dist_in = dist_ff;
            end
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (!last_ff) begin
               state_in = S_IDLE;
            end else if (!rsp_valid_ff || rsp_tready) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_data_in  = best_id_ff;
               best_id_in   = '0;
               best_dist_in = '0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         best_id_ff   <= '0;
         best_dist_ff <= '0;
         prod_vld_ff  <= 1'b0;
         origin_ff[0] <= '0;
         origin_ff[1] <= '0;
         origin_ff[2] <= '0;
         dir_ff[0]    <= '0;
         dir_ff[1]    <= '0;
         dir_ff[2]    <= DirZReset;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_data_ff  <= rsp_data_in;
         best_id_ff   <= best_id_in;
         best_dist_ff <= best_dist_in;
         prod_vld_ff  <= prod_vld_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_ORIGIN_X: origin_ff[0] <= signed'(csr_data);
               CSR_ORIGIN_Y: origin_ff[1] <= signed'(csr_data);
               CSR_ORIGIN_Z: origin_ff[2] <= signed'(csr_data);
               CSR_DIR_X:    dir_ff[0]    <= signed'(csr_data[DirW-1:0]);
               CSR_DIR_Y:    dir_ff[1]    <= signed'(csr_data[DirW-1:0]);
               CSR_DIR_Z:    dir_ff[2]    <= signed'(csr_data[DirW-1:0]);
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      off_ff     <= off_in;
      radius_ff  <= radius_in;
      id_ff      <= id_in;
      last_ff    <= last_in;
      prod_ff    <= prod_in;
      prod_op_ff <= prod_op_in;
      b_ff       <= b_in;
      acc_ff     <= acc_in;
      rem_ff     <= rem_in;
      root_ff    <= root_in;
      dist_ff    <= dist_in;
      hit_ff     <= hit_in;
   end

   `RSNP_ASSERT_NEXT(a_busy_after_accept, clock, reset, accept, !req_tready)
   `RSNP_ASSERT_NEXT(a_emit_clears_best, clock, reset, rsp_load, rsp_tvalid && best_id_ff == '0)
   `RSNP_ASSERT_IMPLY(a_valid_rise_from_emit, clock, reset, $rose(rsp_tvalid), $past(rsp_load))

endmodule

`default_nettype wire

// ----- tb/sv/tb_ray_sphere_nearest_pick.sv -----
// testbench for ray_sphere_nearest_pick: pick lists are streamed in and every
// picked id is checked against a predictor kept inside this module
// depends on rsnp_pkg and the ray_sphere_nearest_pick top level
`timescale 1ns / 100ps

module tb_ray_sphere_nearest_pick;
   import rsnp_pkg::*;

   localparam int unsigned U            = 65536;      // 1.0 in Q16.16
   localparam int unsigned SETTLE       = 100;        // more cycles than a hit sphere takes
   localparam int unsigned CYCLE_LIMIT  = 1000000;
   localparam logic [CsrIdxW-1:0] CSR_SPARE_6 = 3'd6;
   localparam logic [CsrIdxW-1:0] CSR_SPARE_7 = 3'd7;

   typedef struct {
      logic [2:0][CoordW-1:0] center;   // x, y, z
      logic [RadiusW-1:0]     radius;
      logic [IdW-1:0]         id;
      logic                   sphere_valid;
      logic                   last_sphere;
   } sphere_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [CsrIdxW-1:0]  csr_index = '0;
   logic [CsrDataW-1:0] csr_data = '0;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [ReqDataW-1:0] req_tdata = '0;
   logic                req_tuser = 1'b0;
   logic                req_tlast = 1'b0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [IdW-1:0]      rsp_tdata;

   ray_sphere_nearest_pick dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #10 clock = ~clock;

   // predictor state: ray copy and nearest-hit tracking
   logic signed [CoordW-1:0] ray_origin [3] = '{32'sd0, 32'sd0, 32'sd0};
   logic signed [DirW-1:0]   ray_dir [3]    = '{16'sd0, 16'sd0, DirZReset};
   logic [IdW-1:0]           nearest_id = '0;
   longint                   nearest_dist = 0;
   logic [IdW-1:0]           picked_ids_q [$];

   int unsigned req_idle_pct = 0;
   int unsigned rsp_stall_pct = 0;
   int unsigned mismatches = 0;
   int unsigned ids_checked = 0;
   int unsigned items_sent = 0;
   int unsigned useful_items = 0;
   int unsigned ray_settings = 0;
   int unsigned cycles = 0;
   logic [IdW-1:0] want_id;

   task automatic report_mismatch(string what, logic [IdW-1:0] got, logic [IdW-1:0] want);
      $display("mismatch: %s got %h want %h at cycle %0d", what, got, want, cycles);
      mismatches++;
   endtask

   function automatic logic [63:0] root_floor(logic [127:0] v);
      logic [63:0] r;
      logic [63:0] cand;
      logic [127:0] sq;
      r = '0;
      for (int bit_i = 50; bit_i >= 0; bit_i--) begin
         cand = r | (64'd1 << bit_i);
         sq = {64'd0, cand} * {64'd0, cand};
         if (sq <= v) r = cand;
      end
      return r;
   endfunction

   task automatic trace_sphere(sphere_type s);
      longint off;
      longint b;
      longint hit_dist;
      logic [63:0] m;
      logic [63:0] bmag;
      logic [63:0] root;
      logic [127:0] sumsq;
      logic [127:0] rsq;
      logic [127:0] p;
      logic [127:0] q;
      b = 0;
      sumsq = '0;
      for (int a = 0; a < 3; a++) begin
         off = longint'(ray_origin[a]) - longint'($signed(s.center[a]));
         b += off * longint'(ray_dir[a]);
         m = (off < 0) ? -off : off;
         sumsq += {64'd0, m} * {64'd0, m};
      end
      bmag = (b < 0) ? -b : b;
      rsq = {97'd0, s.radius} * {97'd0, s.radius};
      p = {64'd0, bmag} * {64'd0, bmag} + (rsq << ScaleSh);
      q = sumsq << ScaleSh;
      if (p < q) return;
      root = root_floor(p - q);
      hit_dist = -b - longint'(root);
      // origin inside the sphere: take the far crossing
      if (hit_dist < 0) hit_dist = -b + longint'(root);
      if (hit_dist < 0) return;
      // a stored id of zero stands for nothing found yet
      if (nearest_id == '0 || hit_dist < nearest_dist) begin
         nearest_id = s.id;
         nearest_dist = hit_dist;
      end
   endtask

   task automatic predict_item(sphere_type s);
      if (s.sphere_valid) trace_sphere(s);
      if (s.last_sphere) begin
         picked_ids_q = {picked_ids_q, nearest_id};
         nearest_id = '0;
         nearest_dist = 0;
      end
   endtask

   task automatic send_item(sphere_type s);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tdata  <= {1'b0, s.id, s.radius, s.center};
      req_tuser  <= s.sphere_valid;
      req_tlast  <= s.last_sphere;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      predict_item(s);
      items_sent++;
      if (s.sphere_valid || s.last_sphere) useful_items++;
   endtask

   // wait for every picked id, then let a sphere without a result finish
   task automatic wait_for_idle();
      req_tvalid <= 1'b0;
      while (picked_ids_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_csr(logic [CsrIdxW-1:0] idx, logic [CsrDataW-1:0] data);
      csr_index <= idx;
      csr_data  <= data;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_ORIGIN_X: ray_origin[0] = data;
         CSR_ORIGIN_Y: ray_origin[1] = data;
         CSR_ORIGIN_Z: ray_origin[2] = data;
         CSR_DIR_X:    ray_dir[0] = data[DirW-1:0];
         CSR_DIR_Y:    ray_dir[1] = data[DirW-1:0];
         CSR_DIR_Z:    ray_dir[2] = data[DirW-1:0];
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_ray(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                          logic [15:0] dx, logic [15:0] dy, logic [15:0] dz);
      wait_for_idle();
      write_csr(CSR_ORIGIN_X, ox);
      write_csr(CSR_ORIGIN_Y, oy);
      write_csr(CSR_ORIGIN_Z, oz);
      // upper data bits are junk for the direction registers
      write_csr(CSR_DIR_X, {16'($urandom), dx});
      write_csr(CSR_DIR_Y, {16'($urandom), dy});
      write_csr(CSR_DIR_Z, {16'($urandom), dz});
      ray_settings++;
   endtask

   task automatic set_random_ray();
      real v [3];
      real len;
      logic [15:0] d [3];
      logic [31:0] o [3];
      do begin
         for (int a = 0; a < 3; a++) v[a] = $urandom_range(0, 2000) / 1000.0 - 1.0;
         len = $sqrt(v[0] * v[0] + v[1] * v[1] + v[2] * v[2]);
      end while (len < 0.1);
      for (int a = 0; a < 3; a++) begin
         d[a] = 16'($rtoi(v[a] / len * 16384.0));
         o[a] = 32'($urandom_range(0, 2000 * U)) - 32'(1000 * U);
      end
      // now and then a direction that is not unit length
      if ($urandom_range(9) == 0)
         for (int a = 0; a < 3; a++) d[a] = 16'($urandom);
      set_ray(o[0], o[1], o[2], d[0], d[1], d[2]);
   endtask

   function automatic sphere_type mk_sphere(logic [31:0] cx, logic [31:0] cy,
                                            logic [31:0] cz, logic [30:0] r,
                                            logic [31:0] id, logic sv, logic ls);
      sphere_type s;
      s.center = {cz, cy, cx};
      s.radius = r;
      s.id = id;
      s.sphere_valid = sv;
      s.last_sphere = ls;
      return s;
   endfunction

   function automatic sphere_type random_sphere();
      return mk_sphere($urandom, $urandom, $urandom, 31'($urandom), $urandom, 1'b1, 1'b0);
   endfunction

   // sphere placed along the ray, jittered by up to its radius on each axis
   function automatic sphere_type near_ray_sphere();
      sphere_type s;
      longint rad;
      longint t_raw;
      longint c;
      rad = longint'($urandom_range(1, 8 * U));
      t_raw = longint'($urandom_range(0, 240 * U)) - longint'(40 * U);
      s = random_sphere();
      s.radius = 31'(rad);
      for (int a = 0; a < 3; a++) begin
         c = longint'(ray_origin[a]) + ((longint'(ray_dir[a]) * t_raw) >>> 14)
             + longint'($urandom_range(0, 32'(2 * rad))) - rad;
         s.center[a] = c[31:0];
      end
      return s;
   endfunction

   task automatic run_pick_list();
      int n_spheres;
      int pick;
      bit closed;
      bit have_prev;
      sphere_type s;
      sphere_type prev;
      n_spheres = $urandom_range(0, 5);
      closed = 1'b0;
      have_prev = 1'b0;
      for (int k = 0; k < n_spheres; k++) begin
         pick = $urandom_range(99);
         if (pick < 8) begin
            s = random_sphere();
            s.sphere_valid = 1'b0;
            send_item(s);
         end
         if (have_prev && pick < 18) begin
            s = prev;               // same distance: a tie
            s.id = $urandom;
         end else if (pick < 33) begin
            s = random_sphere();
         end else begin
            s = near_ray_sphere();
         end
         if ($urandom_range(9) == 0) s.id = '0;
         s.sphere_valid = 1'b1;
         s.last_sphere = (k == n_spheres - 1) && ($urandom_range(1) == 1);
         closed = s.last_sphere;
         send_item(s);
         prev = s;
         have_prev = 1'b1;
      end
      if (!closed) begin
         s = random_sphere();
         s.sphere_valid = 1'b0;
         s.last_sphere = 1'b1;
         send_item(s);
      end
   endtask

   task automatic test_directed_lists();
      req_idle_pct = 0;
      rsp_stall_pct = 0;
      // empty list, and one with a stray item that carries no sphere
      send_item(mk_sphere(0, 0, 0, 31'd0, 0, 1'b0, 1'b1));
      send_item(mk_sphere(0, 0, 0, 31'd0, 3, 1'b0, 1'b0));
      send_item(mk_sphere(0, 0, 0, 31'd0, 4, 1'b0, 1'b1));
      // hit, miss, behind, origin inside
      send_item(mk_sphere(0, 0, 10 * U, 31'(U), 5, 1'b1, 1'b1));
      send_item(mk_sphere(5 * U, 0, 10 * U, 31'(U), 7, 1'b1, 1'b1));
      send_item(mk_sphere(0, 0, -10 * U, 31'(U), 9, 1'b1, 1'b1));
      send_item(mk_sphere(0, 0, 0, 31'(2 * U), 11, 1'b1, 1'b1));
      // nearest of three
      send_item(mk_sphere(0, 0, 30 * U, 31'(U), 21, 1'b1, 1'b0));
      send_item(mk_sphere(0, 0, 10 * U, 31'(U), 22, 1'b1, 1'b0));
      send_item(mk_sphere(0, 0, 20 * U, 31'(U), 23, 1'b1, 1'b0));
      send_item(mk_sphere(0, 0, 0, 31'd0, 0, 1'b0, 1'b1));
      // nearest hit with id zero is replaced by a farther one
      send_item(mk_sphere(0, 0, 5 * U, 31'(U), 0, 1'b1, 1'b0));
      send_item(mk_sphere(0, 0, 50 * U, 31'(U), 31, 1'b1, 1'b1));
      // equal distance keeps the first
      send_item(mk_sphere(0, 0, 10 * U, 31'(U), 41, 1'b1, 1'b0));
      send_item(mk_sphere(0, 0, 10 * U, 31'(U), 42, 1'b1, 1'b1));
      // grazing hit, then a hit at distance zero
      send_item(mk_sphere(U, 0, 10 * U, 31'(U), 51, 1'b1, 1'b1));
      send_item(mk_sphere(0, 0, U, 31'(U), 61, 1'b1, 1'b1));
      // field extremes
      send_item(mk_sphere(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'h7fff_ffff,
                          32'hffff_ffff, 1'b1, 1'b0));
      send_item(mk_sphere(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 31'd0,
                          32'hffff_ffff, 1'b1, 1'b1));
      wait_for_idle();
   endtask

   task automatic run_short_lists();
      sphere_type s;
      for (int k = 0; k < 4; k++) begin
         s = random_sphere();
         s.last_sphere = (k == 3);
         send_item(s);
      end
      for (int k = 0; k < 3; k++) begin
         s = near_ray_sphere();
         s.last_sphere = (k == 2);
         send_item(s);
      end
   endtask

   task automatic test_config_extremes();
      req_idle_pct = 15;
      rsp_stall_pct = 15;
      set_ray(32'h7fff_ffff, 32'h8000_0000, 32'd0, 16'sd16384, -16'sd16384, 16'sd0);
      write_csr(CSR_SPARE_6, $urandom);
      write_csr(CSR_SPARE_7, $urandom);
      run_short_lists();
      set_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'h8000, 16'h7fff, 16'h0000);
      run_short_lists();
      set_ray(32'hffff_ffff, 32'h7fff_ffff, 32'h0000_0001, -16'sd16384, 16'sd0, 16'sd16384);
      run_short_lists();
      wait_for_idle();
   endtask

   task automatic test_random_picks(int n, int idle, int stall);
      int unsigned start;
      int unsigned next_ray;
      req_idle_pct = idle;
      rsp_stall_pct = stall;
      set_random_ray();
      start = useful_items;
      next_ray = useful_items + $urandom_range(40, 90);
      while (useful_items - start < n) begin
         if (useful_items >= next_ray) begin
            set_random_ray();
            next_ray = useful_items + $urandom_range(40, 90);
         end
         run_pick_list();
      end
      wait_for_idle();
   endtask

   // result checker and receiver stalls
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (picked_ids_q.size() == 0) begin
            report_mismatch("picked id with none expected", rsp_tdata, '0);
         end else begin
            want_id = picked_ids_q.pop_front();
            if (rsp_tdata !== want_id) report_mismatch("picked_id", rsp_tdata, want_id);
            ids_checked++;
         end
      end
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d ids still expected", cycles,
                  picked_ids_q.size());
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_lists();
      test_config_extremes();
      test_random_picks(250, 0, 0);
      test_random_picks(250, 56, 0);
      test_random_picks(250, 0, 56);
      test_random_picks(250, 15, 15);
      wait_for_idle();
      $display("summary: %0d items over %0d ray settings, %0d picked ids checked",
               items_sent, ray_settings, ids_checked);
      $display("summary: %0d mismatches in %0d cycles", mismatches, cycles);
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
